>>> rtl/pal_pkg.sv
// Shared types and constants of the positional array list engine.
package pal_pkg;

   localparam int POS_W       = 9;
   localparam int PORT_VAL_W  = 32;
   localparam int ACTION_W    = 3;
   localparam int GROUP_SIZE  = 16;
   localparam int GROUP_BITS  = 4;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT_AT     = 3'd0,
      ACT_INSERT_SORTED = 3'd1,
      ACT_ERASE_AT      = 3'd2,
      ACT_REMOVE_ALL    = 3'd3,
      ACT_GET           = 3'd4,
      ACT_SET           = 3'd5,
      ACT_FIND          = 3'd6
   } action_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CMP  = 5'b00010,
      ST_ENC1 = 5'b00100,
      ST_ENC2 = 5'b01000,
      ST_EXEC = 5'b10000
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_ERASE  = 2'd2,
      CELL_WRITE  = 2'd3
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        compare;
      logic        cmp_ge;
   } cell_cmd_type;

endpackage

>>> rtl/positional_array_list_engine.sv
// insert_at, erase_at, set and unused codes go from idle straight to execute; get first passes a compare step.
// insert_sorted and find first compare in every cell, then pass two priority encoder stages.
// remove_all repeats compare, encoder stages and execute, one entry erased per encoder pass.
// Throughput: one transaction at a time; busy is high until the result is shown.
// Reset (synchronous, active high) empties the list; entry contents stay undefined until written.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
module positional_array_list_engine #(
   parameter int CAPACITY   = 256,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [pal_pkg::ACTION_W-1:0]   req_action,
   input  logic [pal_pkg::POS_W-1:0]      req_position,
   input  logic [pal_pkg::PORT_VAL_W-1:0] req_item_value,
   output logic                           rsp_valid,
   output logic                           rsp_ok,
   output logic [pal_pkg::POS_W-1:0]      rsp_result_position,
   output logic [pal_pkg::PORT_VAL_W-1:0] rsp_read_value,
   output logic [pal_pkg::POS_W-1:0]      rsp_list_size,
   output logic                           rsp_is_empty
);
   import pal_pkg::*;

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

   // Transaction registers, captured when start is accepted.
   state_type             state_ff, state_in;
   action_type            action_ff, action_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [ITEM_WIDTH-1:0] value_ff, value_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      removed_ff, removed_in;

   // Result registers.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_ok_ff, rsp_ok_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [PORT_VAL_W-1:0] rsp_rval_ff, rsp_rval_in;
   logic [POS_W-1:0]      rsp_size_ff, rsp_size_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   // Cell row and its broadcast bus.
   cell_cmd_type          cmd;
   logic [IDX_W-1:0]      cell_pos;
   logic [ITEM_WIDTH-1:0] cell_value [CAPACITY];
   logic [ITEM_WIDTH-1:0] cell_rd    [CAPACITY];
   logic [CAPACITY-1:0]   cell_flag;
   logic [ITEM_WIDTH-1:0] rd_or;
   logic                  found;
   logic [IDX_W-1:0]      found_index;

   logic                  accept;
   logic                  not_full;
   logic [CMP_W-1:0]      pos_ext;
   logic [CMP_W-1:0]      cnt_ext;
   logic [IDX_W-1:0]      sorted_index;

   assign accept   = start && !busy;
   assign busy     = (state_ff != ST_IDLE);
   assign not_full = count_ff < CNT_W'(CAPACITY);
   assign pos_ext  = CMP_W'(pos_ff);
   assign cnt_ext  = CMP_W'(count_ff);
   // Sorted insert lands before the first entry not below the value, or appends.
   assign sorted_index = found ? found_index : IDX_W'(count_ff);

   // Each cell takes its lower neighbor on an insert and its upper neighbor on an erase.
   // The end cells feed themselves where no neighbor exists; only the top cell selects that path, on an erase.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      pal_cell #(
         .INDEX      (i),
         .IDX_W      (IDX_W),
         .CNT_W      (CNT_W),
         .ITEM_WIDTH (ITEM_WIDTH)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_pos    (cell_pos),
         .count       (count_ff),
         .item_value  (value_ff),
         .below_value ((i == 0) ? cell_value[i] : cell_value[(i == 0) ? 0 : i - 1]),
         .above_value ((i == CAPACITY - 1) ? cell_value[i]
                                           : cell_value[(i == CAPACITY - 1) ? i : i + 1]),
         .value       (cell_value[i]),
         .flag        (cell_flag[i]),
         .rd_value    (cell_rd[i])
      );
   end

   pal_first_match #(
      .N     (CAPACITY),
      .IDX_W (IDX_W)
   ) u_first_match (
      .clock (clock),
      .flags (cell_flag),
      .found (found),
      .index (found_index)
   );

   // Only the addressed cell captured a nonzero read word, so an OR collects it.
   always_comb begin
      rd_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         rd_or = rd_or | cell_rd[i];
      end
   end

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      pos_in       = pos_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      removed_in   = removed_ff;
      cmd          = '{op: CELL_HOLD, compare: 1'b0, cmp_ge: 1'b0};
      cell_pos     = IDX_W'(pos_ff);
      rsp_valid_in = 1'b0;
      rsp_ok_in    = 1'b0;
      rsp_pos_in   = '0;
      rsp_rval_in  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               action_in  = action_type'(req_action);
               pos_in     = req_position;
               value_in   = ITEM_WIDTH'(req_item_value);
               removed_in = '0;
               unique case (action_type'(req_action)) inside
                  ACT_INSERT_SORTED, ACT_REMOVE_ALL, ACT_FIND, ACT_GET: state_in = ST_CMP;
                  default:                                             state_in = ST_EXEC;
               endcase
            end
         end
         ST_CMP: begin
            // Every cell compares its entry against the broadcast value at once.
            cmd.compare = 1'b1;
            cmd.cmp_ge  = (action_ff == ACT_INSERT_SORTED);
            state_in    = (action_ff == ACT_GET) ? ST_EXEC : ST_ENC1;
         end
         ST_ENC1: state_in = ST_ENC2;
         ST_ENC2: state_in = ST_EXEC;
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (action_ff)
               ACT_INSERT_AT: begin
                  if (pos_ext <= cnt_ext && not_full) begin
                     cmd.op     = CELL_INSERT;
                     count_in   = count_ff + 1'b1;
                     rsp_ok_in  = 1'b1;
                     rsp_pos_in = pos_ff;
                  end
               end
               ACT_INSERT_SORTED: begin
                  if (not_full) begin
                     cmd.op     = CELL_INSERT;
                     cell_pos   = sorted_index;
                     count_in   = count_ff + 1'b1;
                     rsp_ok_in  = 1'b1;
                     rsp_pos_in = POS_W'(sorted_index);
                  end
               end
               ACT_ERASE_AT: begin
                  if (pos_ext < cnt_ext) begin
                     cmd.op     = CELL_ERASE;
                     count_in   = count_ff - 1'b1;
                     rsp_ok_in  = 1'b1;
                     rsp_pos_in = pos_ff;
                  end
               end
               ACT_REMOVE_ALL: begin
                  // Erase the first match and search again until none is left.
                  if (found) begin
                     cmd.op       = CELL_ERASE;
                     cell_pos     = found_index;
                     count_in     = count_ff - 1'b1;
                     removed_in   = removed_ff + 1'b1;
                     state_in     = ST_CMP;
                     rsp_valid_in = 1'b0;
                  end else begin
                     rsp_ok_in  = 1'b1;
                     rsp_pos_in = POS_W'(removed_ff);
                  end
               end
               ACT_GET: begin
                  if (pos_ext < cnt_ext) begin
                     rsp_ok_in   = 1'b1;
                     rsp_pos_in  = pos_ff;
                     rsp_rval_in = PORT_VAL_W'(rd_or);
                  end
               end
               ACT_SET: begin
                  if (pos_ext < cnt_ext) begin
                     cmd.op     = CELL_WRITE;
                     rsp_ok_in  = 1'b1;
                     rsp_pos_in = pos_ff;
                  end
               end
               ACT_FIND: begin
                  if (found) begin
                     rsp_ok_in  = 1'b1;
                     rsp_pos_in = POS_W'(found_index);
                  end
               end
               default: rsp_ok_in = 1'b0;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase

      rsp_size_in  = POS_W'(count_in);
      rsp_empty_in = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      pos_ff       <= pos_in;
      value_ff     <= value_in;
      removed_ff   <= removed_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_rval_ff  <= rsp_rval_in;
      rsp_size_ff  <= rsp_size_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_result_position = rsp_pos_ff;
   assign rsp_read_value      = rsp_rval_ff;
   assign rsp_list_size       = rsp_size_ff;
   assign rsp_is_empty        = rsp_empty_ff;

`ifndef NO_ASSERTIONS
   // The fill count never passes the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("list count above capacity");

   // A result only follows the execute step.
   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_EXEC))
      else $error("result without execute step");

   // While a result is shown the engine is idle and ready for the next transaction.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("result shown while busy");

   // A remove_all pass that erased an entry goes back to compare without answering.
   a_remove_loop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && action_ff == ACT_REMOVE_ALL && found)
         |=> (state_ff == ST_CMP && !rsp_valid_ff))
      else $error("remove_all pass ended early");
`endif

endmodule

>>> rtl/pal_cell.sv
// One storage cell of the list: holds an entry, shifts with its neighbors, compares.
module pal_cell #(
   parameter int INDEX      = 0,
   parameter int IDX_W      = 8,
   parameter int CNT_W      = 9,
   parameter int ITEM_WIDTH = 32
) (
   input  logic                   clock,
   input  pal_pkg::cell_cmd_type  cmd,
   input  logic [IDX_W-1:0]       cell_pos,
   input  logic [CNT_W-1:0]       count,
   input  logic [ITEM_WIDTH-1:0]  item_value,
   input  logic [ITEM_WIDTH-1:0]  below_value,
   input  logic [ITEM_WIDTH-1:0]  above_value,
   output logic [ITEM_WIDTH-1:0]  value,
   output logic                   flag,
   output logic [ITEM_WIDTH-1:0]  rd_value
);
   import pal_pkg::*;

   logic [ITEM_WIDTH-1:0] value_ff, value_in;
   logic                  flag_ff, flag_in;
   logic [ITEM_WIDTH-1:0] rd_ff, rd_in;
   logic                  in_use;
   logic                  at_pos;
   logic                  above_pos;

   assign in_use    = CNT_W'(INDEX) < count;
   assign at_pos    = IDX_W'(INDEX) == cell_pos;
   assign above_pos = IDX_W'(INDEX) > cell_pos;

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (above_pos) begin
               value_in = below_value;
            end else if (at_pos) begin
               value_in = item_value;
            end
         end
         CELL_ERASE: begin
            if (above_pos || at_pos) begin
               value_in = above_value;
            end
         end
         CELL_WRITE: begin
            if (at_pos) begin
               value_in = item_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   // Flags used entries not below the value for sorted insert, else equal ones.
   always_comb begin
      flag_in = flag_ff;
      rd_in   = rd_ff;
      if (cmd.compare) begin
         if (cmd.cmp_ge) begin
            flag_in = in_use && (item_value <= value_ff);
         end else begin
            flag_in = in_use && (item_value == value_ff);
         end
         rd_in = at_pos ? value_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      flag_ff  <= flag_in;
      rd_ff    <= rd_in;
   end

   assign value    = value_ff;
   assign flag     = flag_ff;
   assign rd_value = rd_ff;

endmodule

>>> rtl/pal_first_match.sv
// Two-stage registered priority encoder that finds the lowest set flag.
module pal_first_match #(
   parameter int N     = 256,
   parameter int IDX_W = 8
) (
   input  logic             clock,
   input  logic [N-1:0]     flags,
   output logic             found,
   output logic [IDX_W-1:0] index
);
   import pal_pkg::*;

   localparam int NUM_GROUPS = (N + GROUP_SIZE - 1) / GROUP_SIZE;
   localparam int PADDED     = NUM_GROUPS * GROUP_SIZE;
   localparam int GIDX_W     = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

   logic [PADDED-1:0]     flags_pad;
   logic [NUM_GROUPS-1:0] any_ff, any_in;
   logic [GROUP_BITS-1:0] low_ff [NUM_GROUPS];
   logic [GROUP_BITS-1:0] low_in [NUM_GROUPS];
   logic                  found_ff, found_in;
   logic [IDX_W-1:0]      index_ff, index_in;
   logic [GIDX_W-1:0]     grp;
   logic [GROUP_BITS-1:0] grp_low;

   assign flags_pad = PADDED'(flags);

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         any_in[g] = |flags_pad[g*GROUP_SIZE +: GROUP_SIZE];
         low_in[g] = '0;
         for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
            if (flags_pad[g*GROUP_SIZE + j]) begin
               low_in[g] = GROUP_BITS'(j);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      any_ff <= any_in;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         low_ff[g] <= low_in[g];
      end
   end

   always_comb begin
      grp      = '0;
      grp_low  = '0;
      found_in = |any_ff;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (any_ff[g]) begin
            grp     = GIDX_W'(g);
            grp_low = low_ff[g];
         end
      end
      index_in = IDX_W'({grp, grp_low});
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      index_ff <= index_in;
   end

   assign found = found_ff;
   assign index = index_ff;

endmodule

>>> tb/pal_list_checker_pkg.sv
// Scoreboard class that tracks the list contents and checks each engine response.
package pal_list_checker_pkg;

   import pal_pkg::*;

   localparam int unsigned LIST_CAPACITY = 256;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 3'd7;

   typedef struct packed {
      logic                  ok;
      logic [POS_W-1:0]      position;
      logic [PORT_VAL_W-1:0] read_value;
      logic [POS_W-1:0]      list_size;
      logic                  is_empty;
   } list_response_type;

   class list_checker;
      logic [PORT_VAL_W-1:0] slots [LIST_CAPACITY];
      int unsigned           held;
      list_response_type     awaited[$];
      int unsigned           failures;

      function new();
         held     = 0;
         failures = 0;
      endfunction

      function bit try_insert(int unsigned at, logic [PORT_VAL_W-1:0] val);
         int unsigned i;
         if (at > held || held >= LIST_CAPACITY) return 1'b0;
         for (i = held; i > at; i--) slots[i] = slots[i-1];
         slots[at] = val;
         held++;
         return 1'b1;
      endfunction

      // Applies one operation to the tracked list and returns the response it should give.
      function list_response_type apply_operation(logic [ACTION_W-1:0] act,
                                                  logic [POS_W-1:0] pos,
                                                  logic [PORT_VAL_W-1:0] val);
         list_response_type r;
         int unsigned       at, kept, i;
         r = '0;
         case (act)
            ACT_INSERT_AT: begin
               if (try_insert(pos, val)) begin
                  r.ok       = 1'b1;
                  r.position = pos;
               end
            end
            ACT_INSERT_SORTED: begin
               at = held;
               for (i = 0; i < held; i++) begin
                  if (val <= slots[i]) begin
                     at = i;
                     break;
                  end
               end
               if (try_insert(at, val)) begin
                  r.ok       = 1'b1;
                  r.position = POS_W'(at);
               end
            end
            ACT_ERASE_AT: begin
               if (pos < held) begin
                  for (i = pos; i + 1 < held; i++) slots[i] = slots[i+1];
                  held--;
                  r.ok       = 1'b1;
                  r.position = pos;
               end
            end
            ACT_REMOVE_ALL: begin
               kept = 0;
               for (i = 0; i < held; i++) begin
                  if (slots[i] != val) begin
                     slots[kept] = slots[i];
                     kept++;
                  end
               end
               r.ok       = 1'b1;
               r.position = POS_W'(held - kept);
               held       = kept;
            end
            ACT_GET: begin
               if (pos < held) begin
                  r.ok         = 1'b1;
                  r.position   = pos;
                  r.read_value = slots[pos];
               end
            end
            ACT_SET: begin
               if (pos < held) begin
                  slots[pos] = val;
                  r.ok       = 1'b1;
                  r.position = pos;
               end
            end
            ACT_FIND: begin
               for (i = 0; i < held; i++) begin
                  if (slots[i] == val) begin
                     r.ok       = 1'b1;
                     r.position = POS_W'(i);
                     break;
                  end
               end
            end
            default: ;
         endcase
         r.list_size = POS_W'(held);
         r.is_empty  = (held == 0);
         return r;
      endfunction

      function void note_command(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                                 logic [PORT_VAL_W-1:0] val);
         awaited.push_back(apply_operation(act, pos, val));
      endfunction

      function void compare_field(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_response(list_response_type got);
         list_response_type want;
         if (awaited.size() == 0) begin
            $error("response strobe with no transaction outstanding");
            failures++;
            return;
         end
         want = awaited.pop_front();
         compare_field("rsp_ok", want.ok, got.ok);
         compare_field("rsp_result_position", want.position, got.position);
         compare_field("rsp_read_value", want.read_value, got.read_value);
         compare_field("rsp_list_size", want.list_size, got.list_size);
         compare_field("rsp_is_empty", want.is_empty, got.is_empty);
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      function logic [PORT_VAL_W-1:0] sample_stored();
         if (held == 0) return $urandom();
         return slots[$urandom_range(0, held - 1)];
      endfunction
   endclass

endpackage

>>> tb/positional_array_list_engine_tb.sv
// Self-checking testbench of the positional array list engine.
module positional_array_list_engine_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import pal_pkg::*;
   import pal_list_checker_pkg::*;

   // All inputs hold known values from time zero; reset starts high.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic [ACTION_W-1:0]   req_action = '0;
   logic [POS_W-1:0]      req_position = '0;
   logic [PORT_VAL_W-1:0] req_item_value = '0;

   logic                  busy;
   logic                  rsp_valid;
   logic                  rsp_ok;
   logic [POS_W-1:0]      rsp_result_position;
   logic [PORT_VAL_W-1:0] rsp_read_value;
   logic [POS_W-1:0]      rsp_list_size;
   logic                  rsp_is_empty;

   list_checker book;
   int unsigned burst_left = 0;

   always #2 clock = ~clock;

   positional_array_list_engine u_top (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_action          (req_action),
      .req_position        (req_position),
      .req_item_value      (req_item_value),
      .rsp_valid           (rsp_valid),
      .rsp_ok              (rsp_ok),
      .rsp_result_position (rsp_result_position),
      .rsp_read_value      (rsp_read_value),
      .rsp_list_size       (rsp_list_size),
      .rsp_is_empty        (rsp_is_empty)
   );

   // The receiver cannot stall, so every strobe is a response transaction to check.
   // Outputs are read right after the edge, before any register of the block updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         book.check_response({rsp_ok, rsp_result_position, rsp_read_value,
                              rsp_list_size, rsp_is_empty});
      end
   end

   // Presents one command and holds it until the engine takes it, that is until an
   // edge at which busy is low. The command is booked into the scoreboard at that edge,
   // so the tracked list is current when the next command is chosen. Start is left high;
   // the pacing task lowers it only when a gap follows.
   task automatic send_item(logic [ACTION_W-1:0] act, logic [POS_W-1:0] pos,
                            logic [PORT_VAL_W-1:0] val);
      start          <= 1'b1;
      req_action     <= act;
      req_position   <= pos;
      req_item_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      book.note_command(act, pos, val);
   endtask

   // The sender works in bursts of random length. Between bursts it idles for a random
   // gap, and now and then for a long one, so the engine sees both back-to-back commands
   // and commands that arrive well after it went idle.
   task automatic pace();
      int unsigned gap;
      if (burst_left != 0) begin
         burst_left--;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            9:       gap = $urandom_range(12, 40);
            default: gap = $urandom_range(1, 6);
         endcase
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // Growing mode favors inserts so the list fills to capacity; shrinking mode favors
   // erases and bulk removals so it drains back toward empty. Reads, writes and finds
   // are spread over both.
   function automatic logic [ACTION_W-1:0] pick_action(bit growing);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (growing) begin
         if (r < 36) return ACT_INSERT_AT;
         if (r < 66) return ACT_INSERT_SORTED;
         if (r < 71) return ACT_ERASE_AT;
         if (r < 72) return ACT_REMOVE_ALL;
         if (r < 80) return ACT_GET;
         if (r < 87) return ACT_SET;
         if (r < 98) return ACT_FIND;
      end else begin
         if (r < 8)  return ACT_INSERT_AT;
         if (r < 15) return ACT_INSERT_SORTED;
         if (r < 50) return ACT_ERASE_AT;
         if (r < 62) return ACT_REMOVE_ALL;
         if (r < 74) return ACT_GET;
         if (r < 84) return ACT_SET;
         if (r < 98) return ACT_FIND;
      end
      return ACT_UNUSED;
   endfunction

   // Positions cluster on the valid range and its boundaries, with a share drawn
   // from the whole port range so out-of-range requests keep being exercised.
   function automatic logic [POS_W-1:0] pick_position();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return POS_W'($urandom_range(0, book.held));
      if (r < 75) return POS_W'(book.held == 0 ? 0 : book.held - 1);
      if (r < 85) return POS_W'(book.held);
      return POS_W'($urandom_range(0, 511));
   endfunction

   // A small pool of values, extremes included, makes duplicates common so that
   // bulk removal and find have real matches. Stored values give find and sorted
   // insert exact hits; fully random values cover every bit of the field.
   function automatic logic [PORT_VAL_W-1:0] pick_value();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4) begin
         case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'h0000_0001;
            2:       return 32'h0000_0002;
            3:       return 32'h0000_0003;
            4:       return 32'h7FFF_FFFF;
            5:       return 32'h8000_0000;
            6:       return 32'hFFFF_FFFE;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (r < 7) return book.sample_stored();
      return $urandom();
   endfunction

   initial begin
      bit          growing;
      int unsigned full_linger;
      int unsigned low_mark;

      book = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part. On the empty list every positional operation fails, remove-all
      // succeeds with a count of zero and find misses. Then the list is built by
      // positional and sorted inserts, including an append past every entry, and read,
      // written, searched and trimmed at both ends. Positions at and past the end,
      // including the all-ones port value, must fail, as must the unused action code.
      send_item(ACT_GET,           9'd0,   32'h0000_0000); pace();
      send_item(ACT_ERASE_AT,      9'd0,   32'h0000_0000); pace();
      send_item(ACT_SET,           9'd0,   32'hDEAD_BEEF); pace();
      send_item(ACT_FIND,          9'd0,   32'h0000_0000); pace();
      send_item(ACT_REMOVE_ALL,    9'd0,   32'h0000_0000); pace();
      send_item(ACT_INSERT_AT,     9'd1,   32'h1234_5678); pace();
      send_item(ACT_UNUSED,        9'd0,   32'h0000_0000); pace();
      send_item(ACT_INSERT_AT,     9'd0,   32'h8000_0000); pace();
      send_item(ACT_INSERT_AT,     9'd1,   32'h0000_0000); pace();
      send_item(ACT_INSERT_SORTED, 9'd0,   32'hFFFF_FFFF); pace();
      send_item(ACT_INSERT_SORTED, 9'd0,   32'h0000_0000); pace();
      send_item(ACT_INSERT_AT,     9'd0,   32'hFFFF_FFFF); pace();
      send_item(ACT_GET,           9'd4,   32'h0000_0000); pace();
      send_item(ACT_GET,           9'd5,   32'h0000_0000); pace();
      send_item(ACT_GET,           9'd511, 32'h0000_0000); pace();
      send_item(ACT_GET,           9'd256, 32'h0000_0000); pace();
      send_item(ACT_SET,           9'd1,   32'h5A5A_5A5A); pace();
      send_item(ACT_FIND,          9'd0,   32'hFFFF_FFFF); pace();
      send_item(ACT_FIND,          9'd0,   32'h1234_5678); pace();
      send_item(ACT_ERASE_AT,      9'd4,   32'h0000_0000); pace();
      send_item(ACT_ERASE_AT,      9'd0,   32'h0000_0000); pace();
      send_item(ACT_REMOVE_ALL,    9'd0,   32'h0000_0000); pace();
      send_item(ACT_ERASE_AT,      9'd511, 32'h0000_0000); pace();
      send_item(ACT_INSERT_AT,     9'd511, 32'hA5A5_A5A5); pace();
      send_item(ACT_UNUSED,        9'd511, 32'hFFFF_FFFF); pace();

      // Random part. The list alternates between filling to capacity, where it lingers
      // for a while so inserts into a full list are tried, and draining to a small
      // random size, so every fill level and both boundaries are visited repeatedly.
      growing     = 1'b1;
      full_linger = 8;
      low_mark    = 0;
      for (int n = 0; n < 2000; n++) begin
         if (growing && book.held == LIST_CAPACITY) begin
            if (full_linger == 0) begin
               growing  = 1'b0;
               low_mark = $urandom_range(0, 24);
            end else begin
               full_linger--;
            end
         end else if (!growing && book.held <= low_mark) begin
            growing     = 1'b1;
            full_linger = $urandom_range(4, 16);
         end
         send_item(pick_action(growing), pick_position(), pick_value());
         pace();
      end
      start <= 1'b0;

      // Every command yields one response, so the run is drained once nothing is
      // outstanding; a final wait catches any stray strobe.
      while (book.outstanding() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (book.failures == 0) begin
         $display("** positional_array_list_engine: PASSED **");
      end else begin
         $display("** positional_array_list_engine: FAILED **");
      end
      $finish;
   end

   // Watchdog. A full list emptied by one bulk removal is the longest transaction;
   // this bound covers every transaction taking that long, several times over.
   initial begin
      #40_000_000;
      $display("** positional_array_list_engine: FAILED **");
      $finish;
   end

endmodule
